FILE: src/erv_pkg.sv
package erv_pkg;

    localparam int PT_W      = 24;
    localparam int ANG_W     = 17;
    localparam int OUT_W     = 17;
    localparam int CS_W      = 32;
    localparam int CD_W      = 34;
    localparam int R_W       = 33;
    localparam int PROD_W    = PT_W + R_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int M_W       = 15;
    localparam int Q_FRAC    = 30;

    localparam int DEF_CORDIC_STEPS    = 16;
    localparam int DEF_POINT_FRAC_BITS = 8;

    localparam logic signed [19:0] RAD_PER_CDEG   = 20'sd187403;
    localparam logic signed [CD_W-1:0] INV_GAIN   = CD_W'(652032874);
    localparam logic signed [ACC_W-1:0] OUT_MAX_Q = ACC_W'(65535);
    localparam logic signed [ACC_W-1:0] OUT_MIN_Q = ACC_W'(65536);

    typedef struct packed {
        logic signed [CD_W-1:0] x;
        logic signed [CD_W-1:0] y;
        logic signed [CD_W-1:0] z;
        logic                   neg;
    } cordic_t;

    typedef struct packed {
        logic signed [CS_W-1:0] s;
        logic signed [CS_W-1:0] c;
    } sincos_t;

    typedef struct packed {
        logic signed [R_W-1:0] r00;
        logic signed [R_W-1:0] r01;
        logic signed [R_W-1:0] r02;
        logic signed [R_W-1:0] r10;
        logic signed [R_W-1:0] r11;
        logic signed [R_W-1:0] r12;
        logic signed [R_W-1:0] r20;
        logic signed [R_W-1:0] r21;
        logic signed [R_W-1:0] r22;
    } rmat_t;

    function automatic logic signed [CD_W-1:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000008;
            28: v = 32'h00000004;
            29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return CD_W'(v);
    endfunction

    // Q30 product rounded back to Q30: floor((a*b + 2^29) / 2^30).
    function automatic logic signed [R_W-1:0] mulq(input logic signed [R_W-1:0] a,
                                                   input logic signed [R_W-1:0] b);
        logic signed [2*R_W-1:0] p;
        p = a * b;
        p = p + ((2*R_W)'(1) <<< (Q_FRAC - 1));
        return p[Q_FRAC +: R_W];
    endfunction

endpackage

FILE: src/erv_angle.sv
module erv_angle
    import erv_pkg::*;
(
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [ANG_W-1:0] angle,
    output cordic_t                 start
);

    logic signed [M_W-1:0] m_reg, m_next;
    logic                  neg_reg, neg_next;
    logic signed [17:0]    t;

    always_comb begin
        t = 18'(angle);
        if (t >= 18'sd18000) begin
            t = t - 18'sd36000;
        end
        if (t >= 18'sd18000) begin
            t = t - 18'sd36000;
        end
        if (t < -18'sd18000) begin
            t = t + 18'sd36000;
        end
        if (t < -18'sd18000) begin
            t = t + 18'sd36000;
        end
        neg_next = 1'b0;
        if (t > 18'sd9000) begin
            t = t - 18'sd18000;
            neg_next = 1'b1;
        end else if (t < -18'sd9000) begin
            t = t + 18'sd18000;
            neg_next = 1'b1;
        end
        m_next = t[M_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg      <= m_next;
            neg_reg    <= neg_next;
            start.x    <= INV_GAIN;
            start.y    <= '0;
            start.z    <= CD_W'(m_reg) * RAD_PER_CDEG;
            start.neg  <= neg_reg;
        end
    end

endmodule

FILE: src/erv_cell.sv
module erv_cell
    import erv_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic    aclk,
    input  logic    en,
    input  cordic_t cin,
    output cordic_t cout
);

    localparam logic signed [CD_W-1:0] ATAN = atan_q30(STEP);

    cordic_t cell_next;
    logic signed [CD_W-1:0] xs, ys;

    always_comb begin
        xs = cin.x >>> STEP;
        ys = cin.y >>> STEP;
        cell_next.neg = cin.neg;
        if (cin.z >= 0) begin
            cell_next.x = cin.x - ys;
            cell_next.y = cin.y + xs;
            cell_next.z = cin.z - ATAN;
        end else begin
            cell_next.x = cin.x + ys;
            cell_next.y = cin.y - xs;
            cell_next.z = cin.z + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cout <= cell_next;
        end
    end

endmodule

FILE: src/erv_mat.sv
module erv_mat
    import erv_pkg::*;
(
    input  logic    aclk,
    input  logic    en,
    input  cordic_t yaw_c,
    input  cordic_t pitch_c,
    input  cordic_t roll_c,
    output rmat_t   rmat
);

    sincos_t a_reg, b_reg, t_reg;
    logic signed [R_W-1:0] sa, ca, sb, cb, st, ct;
    logic signed [R_W-1:0] stsb_reg, ctsb_reg, cbca_reg, cbsa_reg, ctsa_reg;
    logic signed [R_W-1:0] stsa_reg, ctca_reg, stca_reg, stcb_reg, ctcb_reg, sb_reg;
    logic signed [R_W-1:0] sa_reg, ca_reg;
    logic signed [R_W-1:0] p01_reg, p02_reg, p11_reg, p12_reg;
    logic signed [R_W-1:0] cbca2_reg, cbsa2_reg, ctsa2_reg, stsa2_reg;
    logic signed [R_W-1:0] ctca2_reg, stca2_reg, stcb2_reg, ctcb2_reg, sb2_reg;

    function automatic sincos_t fold(input cordic_t c);
        sincos_t r;
        r.c = c.neg ? CS_W'(-c.x) : CS_W'(c.x);
        r.s = c.neg ? CS_W'(-c.y) : CS_W'(c.y);
        return r;
    endfunction

    assign sa = R_W'(a_reg.s);
    assign ca = R_W'(a_reg.c);
    assign sb = R_W'(b_reg.s);
    assign cb = R_W'(b_reg.c);
    assign st = R_W'(t_reg.s);
    assign ct = R_W'(t_reg.c);

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg <= fold(yaw_c);
            b_reg <= fold(pitch_c);
            t_reg <= fold(roll_c);

            stsb_reg <= mulq(st, sb);
            ctsb_reg <= mulq(ct, sb);
            cbca_reg <= mulq(cb, ca);
            cbsa_reg <= mulq(cb, sa);
            ctsa_reg <= mulq(ct, sa);
            stsa_reg <= mulq(st, sa);
            ctca_reg <= mulq(ct, ca);
            stca_reg <= mulq(st, ca);
            stcb_reg <= mulq(st, cb);
            ctcb_reg <= mulq(ct, cb);
            sb_reg   <= sb;
            sa_reg   <= sa;
            ca_reg   <= ca;

            p01_reg   <= mulq(stsb_reg, ca_reg);
            p02_reg   <= mulq(ctsb_reg, ca_reg);
            p11_reg   <= mulq(stsb_reg, sa_reg);
            p12_reg   <= mulq(ctsb_reg, sa_reg);
            cbca2_reg <= cbca_reg;
            cbsa2_reg <= cbsa_reg;
            ctsa2_reg <= ctsa_reg;
            stsa2_reg <= stsa_reg;
            ctca2_reg <= ctca_reg;
            stca2_reg <= stca_reg;
            stcb2_reg <= stcb_reg;
            ctcb2_reg <= ctcb_reg;
            sb2_reg   <= sb_reg;

            rmat.r00 <= cbca2_reg;
            rmat.r01 <= p01_reg - ctsa2_reg;
            rmat.r02 <= p02_reg + stsa2_reg;
            rmat.r10 <= cbsa2_reg;
            rmat.r11 <= p11_reg + ctca2_reg;
            rmat.r12 <= p12_reg - stca2_reg;
            rmat.r20 <= -sb2_reg;
            rmat.r21 <= stcb2_reg;
            rmat.r22 <= ctcb2_reg;
        end
    end

endmodule

FILE: src/euler_rotate_vector3.sv
// Channel  | Handshake          | Payload
// s_       | s_valid, s_ready   | point_x/y/z (Q16.8), yaw/pitch/roll_cdeg
// m_       | m_valid, m_ready   | rotated_x/y/z, rounded integers, saturated
//
// One item enters per cycle while s_ready is high (no stall at the output).
// The depth depends on the row of CORDIC cells, one cell per iteration.
// Reset clears only the valid bits of the pipeline; data registers are not reset.
// When a result waits at the output and m_ready is low, the whole pipeline holds.
module euler_rotate_vector3
    import erv_pkg::*;
#(
    parameter int CORDIC_STEPS    = DEF_CORDIC_STEPS,
    parameter int POINT_FRAC_BITS = DEF_POINT_FRAC_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [PT_W-1:0]  s_point_x,
    input  logic signed [PT_W-1:0]  s_point_y,
    input  logic signed [PT_W-1:0]  s_point_z,
    input  logic signed [ANG_W-1:0] s_yaw_cdeg,
    input  logic signed [ANG_W-1:0] s_pitch_cdeg,
    input  logic signed [ANG_W-1:0] s_roll_cdeg,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [OUT_W-1:0] m_rotated_x,
    output logic signed [OUT_W-1:0] m_rotated_y,
    output logic signed [OUT_W-1:0] m_rotated_z
);

    localparam int LAT    = CORDIC_STEPS + 9;
    localparam int PT_DLY = CORDIC_STEPS + 6;
    localparam int SH     = Q_FRAC + POINT_FRAC_BITS;
    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (SH - 1);

    logic                   en;
    logic [LAT-1:0]         vld_reg;
    logic signed [ANG_W-1:0] ang [3];
    cordic_t                chain [3][CORDIC_STEPS+1];
    rmat_t                  rmat;
    logic signed [PT_W-1:0] px_reg [PT_DLY];
    logic signed [PT_W-1:0] py_reg [PT_DLY];
    logic signed [PT_W-1:0] pz_reg [PT_DLY];
    logic signed [PROD_W-1:0] prod_reg [9];
    logic signed [ACC_W-1:0]  acc_reg [3];

    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    assign ang[0] = s_yaw_cdeg;
    assign ang[1] = s_pitch_cdeg;
    assign ang[2] = s_roll_cdeg;

    for (genvar l = 0; l < 3; l++) begin : g_lane
        erv_angle u_angle (
            .aclk  (aclk),
            .en    (en),
            .angle (ang[l]),
            .start (chain[l][0])
        );
        for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
            erv_cell #(.STEP(k)) u_cell (
                .aclk (aclk),
                .en   (en),
                .cin  (chain[l][k]),
                .cout (chain[l][k+1])
            );
        end
    end

    erv_mat u_mat (
        .aclk    (aclk),
        .en      (en),
        .yaw_c   (chain[0][CORDIC_STEPS]),
        .pitch_c (chain[1][CORDIC_STEPS]),
        .roll_c  (chain[2][CORDIC_STEPS]),
        .rmat    (rmat)
    );

    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] q;
        mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        q   = (mag + HALF) >> SH;
        if (acc[ACC_W-1]) begin
            return (q > OUT_MIN_Q) ? OUT_W'(-OUT_MIN_Q) : OUT_W'(-q);
        end
        return (q > OUT_MAX_Q) ? OUT_W'(OUT_MAX_Q) : OUT_W'(q);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg[0] <= s_point_x;
            py_reg[0] <= s_point_y;
            pz_reg[0] <= s_point_z;
            for (int i = 1; i < PT_DLY; i++) begin
                px_reg[i] <= px_reg[i-1];
                py_reg[i] <= py_reg[i-1];
                pz_reg[i] <= pz_reg[i-1];
            end

            prod_reg[0] <= PROD_W'(px_reg[PT_DLY-1]) * rmat.r00;
            prod_reg[1] <= PROD_W'(py_reg[PT_DLY-1]) * rmat.r01;
            prod_reg[2] <= PROD_W'(pz_reg[PT_DLY-1]) * rmat.r02;
            prod_reg[3] <= PROD_W'(px_reg[PT_DLY-1]) * rmat.r10;
            prod_reg[4] <= PROD_W'(py_reg[PT_DLY-1]) * rmat.r11;
            prod_reg[5] <= PROD_W'(pz_reg[PT_DLY-1]) * rmat.r12;
            prod_reg[6] <= PROD_W'(px_reg[PT_DLY-1]) * rmat.r20;
            prod_reg[7] <= PROD_W'(py_reg[PT_DLY-1]) * rmat.r21;
            prod_reg[8] <= PROD_W'(pz_reg[PT_DLY-1]) * rmat.r22;

            for (int k = 0; k < 3; k++) begin
                acc_reg[k] <= ACC_W'(prod_reg[3*k]) + ACC_W'(prod_reg[3*k+1])
                            + ACC_W'(prod_reg[3*k+2]);
            end

            m_rotated_x <= round_sat(acc_reg[0]);
            m_rotated_y <= round_sat(acc_reg[1]);
            m_rotated_z <= round_sat(acc_reg[2]);
        end
    end

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted item did not enter the pipeline");

    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!vld_reg[LAT-1] || m_ready))
        else $error("input ready does not follow output stall");

endmodule
